>>> design/twds_pkg.sv
// Shared types, codes, constants and byte-mapping functions for the timed
// wheel drive sequencer. No dependencies; every other design file imports it.
package twds_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int FRAME_N   = 4;

    typedef logic [TIME_W-1:0] t_time;

    // Event codes carried in the input tuser field.
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_UPDATE = 3'd1;
    localparam logic [2:0] MODE_TICK   = 3'd2;
    localparam logic [2:0] MODE_CANCEL = 3'd3;
    localparam logic [2:0] MODE_FINISH = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_READY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_EXT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MARGIN  = 3'd4;

    localparam logic [7:0] SPD_STOP = 8'h40;
    localparam logic [7:0] SPD_MIN  = 8'h42;
    localparam logic [7:0] SPD_TOP  = 8'h4F;
    localparam logic [7:0] DIR_NONE = 8'h00;
    localparam logic [7:0] DIR_CCW  = 8'h34;
    localparam logic [7:0] DIR_CW   = 8'h24;

    localparam logic [6:0] PROG_SCALE = 7'd100;
    localparam logic [6:0] PROG_FULL  = 7'd100;
    localparam logic [6:0] PROG_NONE  = 7'd0;

    // floor(x / 100) for x below 1301 as (x * 5243) >> 19.
    localparam logic [22:0] RECIP_100 = 23'd5243;
    localparam int          RECIP_SH  = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_APPLY,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc;
        logic apply;
        logic prep;
        logic div_step;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic last_beat;
    } t_status;

    function automatic logic [7:0] speed_of(input logic signed [7:0] p);
        logic [7:0]  mag;
        logic [6:0]  mag_c;
        logic [22:0] prod;
        logic [7:0]  spd;
        mag   = p[7] ? (~p + 8'd1) : p;
        mag_c = (mag >= 8'd100) ? 7'd100 : mag[6:0];
        prod  = 23'(mag_c) * 23'd13 * RECIP_100;
        spd   = SPD_MIN + {4'b0000, prod[RECIP_SH+3:RECIP_SH]};
        if (p == 8'sd0) begin
            return SPD_STOP;
        end
        return (spd > SPD_TOP) ? SPD_TOP : spd;
    endfunction

    // The right motor is mounted mirrored, so its direction codes swap.
    function automatic logic [7:0] dir_of(input logic signed [7:0] p, input logic left);
        if (p == 8'sd0) begin
            return DIR_NONE;
        end
        if (!p[7]) begin
            return left ? DIR_CCW : DIR_CW;
        end
        return left ? DIR_CW : DIR_CCW;
    endfunction

endpackage

>>> design/twds_ctrl.sv
// Sequencing state machine of the timed wheel drive sequencer.
// Depends on twds_pkg for the state type and the command and status structs.
module twds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  twds_pkg::t_status i_status,
    output twds_pkg::t_cmd    o_cmd
);
    import twds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC:  n_state = ST_APPLY;
            ST_APPLY: n_state = ST_PREP;
            ST_PREP:  n_state = i_status.need_div ? ST_DIV : ST_EMIT;
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_m_tready && i_status.last_beat) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            ST_CALC:  o_cmd.calc  = 1'b1;
            ST_APPLY: o_cmd.apply = 1'b1;
            ST_PREP:  o_cmd.prep  = 1'b1;
            ST_DIV:   o_cmd.div_step = !i_status.div_done;
            ST_EMIT: begin
                o_m_tvalid     = 1'b1;
                o_cmd.out_next = i_m_tready && !i_status.last_beat;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input accepted while a result beat is pending");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_done) |=> (r_state == ST_EMIT))
        else $error("divider finished but results are not presented");

endmodule

>>> design/twds_dp.sv
// Datapath of the timed wheel drive sequencer: configuration registers, task
// state, frame list, progress divider and result beat selection. Uses twds_pkg.
module twds_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [twds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [twds_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [2:0]                      i_mode,
    input  logic signed [7:0]               i_left_pct,
    input  logic signed [7:0]               i_right_pct,
    input  logic [31:0]                     i_duration_ms,
    input  logic [31:0]                     i_now_ms,
    input  twds_pkg::t_cmd                  i_cmd,
    output twds_pkg::t_status               o_status,
    output logic                            o_frame_valid,
    output logic [7:0]                      o_right_byte,
    output logic [7:0]                      o_left_byte,
    output logic                            o_last,
    output logic                            o_update_accepted,
    output logic                            o_running_now,
    output logic                            o_completed,
    output logic [6:0]                      o_progress_pct
);
    import twds_pkg::*;

    // Configuration.
    logic        r_motor_ready;
    logic [7:0]  r_keepalive;
    logic [15:0] r_min_dur;
    logic [15:0] r_hold_ext;
    logic [15:0] r_margin;

    // Captured event.
    logic [2:0]        r_mode;
    logic signed [7:0] r_lpct;
    logic signed [7:0] r_rpct;
    t_time             r_dur;
    t_time             r_now;
    t_time             r_e_start;
    t_time             r_e_last;
    t_time             r_e_prog;

    // Task state.
    logic       r_running, n_running;
    logic       r_present, n_present;
    t_time      r_start, n_start;
    t_time      r_span, n_span;
    t_time      r_last_send, n_last_send;
    logic [7:0] r_lspd, n_lspd;
    logic [7:0] r_rspd, n_rspd;
    logic [7:0] r_ldir, n_ldir;
    logic [7:0] r_rdir, n_rdir;
    logic       r_accepted, n_accepted;

    // Frame list.
    logic [7:0] r_fr_r [FRAME_N];
    logic [7:0] r_fr_l [FRAME_N];
    logic [7:0] n_fr_r [FRAME_N];
    logic [7:0] n_fr_l [FRAME_N];
    logic [2:0] r_nfr, n_nfr;
    logic [1:0] r_idx;

    // Progress divider.
    logic [6:0] r_prog;
    logic [6:0] r_q;
    t_time      r_rem;
    logic [2:0] r_bit;
    logic       r_ph;
    logic       r_div_done;

    logic [7:0] drv_lspd, drv_rspd, drv_ldir, drv_rdir;
    logic       drive_send, stop_send;
    t_time      min32, ext;
    logic [TIME_W:0] ext_sum, near_sum;
    t_time      target;
    logic       near;

    logic [TIME_W:0] dbl, dbl_red, add, add_red;
    t_time      rem_step;
    logic       q_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_ready <= 1'b1;
            r_keepalive   <= 8'd10;
            r_min_dur     <= 16'd100;
            r_hold_ext    <= 16'd300;
            r_margin      <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOTOR_READY:  r_motor_ready <= i_cfg_wdata[0];
                CFG_KEEPALIVE:    r_keepalive   <= i_cfg_wdata[7:0];
                CFG_MIN_DURATION: r_min_dur     <= i_cfg_wdata;
                CFG_HOLD_EXT:     r_hold_ext    <= i_cfg_wdata;
                CFG_NEAR_MARGIN:  r_margin      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_lpct <= i_left_pct;
            r_rpct <= i_right_pct;
            r_dur  <= i_duration_ms;
            r_now  <= i_now_ms;
        end
        if (i_cmd.calc) begin
            r_e_start <= r_now - r_start;
            r_e_last  <= r_now - r_last_send;
        end
        if (i_cmd.apply) begin
            r_e_prog <= (r_mode == MODE_START) ? '0 : r_e_start;
            for (int k = 0; k < FRAME_N; k++) begin
                r_fr_r[k] <= n_fr_r[k];
                r_fr_l[k] <= n_fr_l[k];
            end
        end
    end

    // Event decode and state update, applied on the apply command.
    always_comb begin
        n_running   = r_running;
        n_present   = r_present;
        n_start     = r_start;
        n_span      = r_span;
        n_last_send = r_last_send;
        n_accepted  = 1'b0;
        drv_lspd    = r_lspd;
        drv_rspd    = r_rspd;
        drv_ldir    = r_ldir;
        drv_rdir    = r_rdir;
        drive_send  = 1'b0;
        stop_send   = 1'b0;

        min32    = {16'b0, r_min_dur};
        ext      = (r_dur >= min32) ? r_dur : {16'b0, r_hold_ext};
        ext_sum  = {1'b0, r_e_start} + {1'b0, ext};
        target   = ext_sum[TIME_W] ? '1 : ext_sum[TIME_W-1:0];
        near_sum = {1'b0, r_e_start} + {17'b0, r_margin};
        near     = (near_sum >= {1'b0, r_span});

        case (r_mode)
            MODE_START: begin
                n_present   = 1'b1;
                n_running   = 1'b1;
                n_start     = r_now;
                n_last_send = r_now;
                n_span      = (r_dur >= min32) ? r_dur : min32;
                drv_lspd    = speed_of(r_lpct);
                drv_rspd    = speed_of(r_rpct);
                drv_ldir    = dir_of(r_lpct, 1'b1);
                drv_rdir    = dir_of(r_rpct, 1'b0);
                drive_send  = r_motor_ready;
            end
            MODE_UPDATE: begin
                if (r_running && r_motor_ready) begin
                    n_accepted  = 1'b1;
                    drv_lspd    = speed_of(r_lpct);
                    drv_rspd    = speed_of(r_rpct);
                    drv_ldir    = dir_of(r_lpct, 1'b1);
                    drv_rdir    = dir_of(r_rpct, 1'b0);
                    drive_send  = 1'b1;
                    n_last_send = r_now;
                    if (near || target > r_span) begin
                        n_span = target;
                    end
                end
            end
            MODE_TICK: begin
                if (r_running) begin
                    if (r_motor_ready && r_e_last >= {24'b0, r_keepalive}) begin
                        drive_send  = 1'b1;
                        n_last_send = r_now;
                    end
                    if (r_e_start >= r_span) begin
                        n_running = 1'b0;
                        stop_send = r_motor_ready;
                    end
                end
            end
            MODE_CANCEL: begin
                if (r_present) begin
                    stop_send = r_motor_ready;
                    n_running = 1'b0;
                    n_present = 1'b0;
                end
            end
            MODE_FINISH: n_present = 1'b0;
            default: begin
            end
        endcase

        n_lspd = stop_send ? SPD_STOP : drv_lspd;
        n_rspd = stop_send ? SPD_STOP : drv_rspd;
        n_ldir = stop_send ? DIR_NONE : drv_ldir;
        n_rdir = stop_send ? DIR_NONE : drv_rdir;

        // Drive frames always come before stop frames.
        n_fr_r[0] = drive_send ? drv_rspd : SPD_STOP;
        n_fr_l[0] = drive_send ? drv_lspd : SPD_STOP;
        n_fr_r[1] = drive_send ? drv_rdir : DIR_NONE;
        n_fr_l[1] = drive_send ? drv_ldir : DIR_NONE;
        n_fr_r[2] = SPD_STOP;
        n_fr_l[2] = SPD_STOP;
        n_fr_r[3] = DIR_NONE;
        n_fr_l[3] = DIR_NONE;
        n_nfr     = {drive_send && stop_send, drive_send ^ stop_send, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_present   <= 1'b0;
            r_start     <= '0;
            r_span      <= '0;
            r_last_send <= '0;
            r_lspd      <= SPD_STOP;
            r_rspd      <= SPD_STOP;
            r_ldir      <= DIR_NONE;
            r_rdir      <= DIR_NONE;
            r_accepted  <= 1'b0;
            r_nfr       <= '0;
        end else if (i_cmd.apply) begin
            r_running   <= n_running;
            r_present   <= n_present;
            r_start     <= n_start;
            r_span      <= n_span;
            r_last_send <= n_last_send;
            r_lspd      <= n_lspd;
            r_rspd      <= n_rspd;
            r_ldir      <= n_ldir;
            r_rdir      <= n_rdir;
            r_accepted  <= n_accepted;
            r_nfr       <= n_nfr;
        end
    end

    // Restoring division of elapsed * 100 by the span, one add and compare
    // per cycle: a doubling step for every bit of 100 and an add of the
    // elapsed time for each set bit. The remainder stays below the span.
    always_comb begin
        dbl     = {r_rem, 1'b0};
        dbl_red = (dbl >= {1'b0, r_span}) ? (dbl - {1'b0, r_span}) : dbl;
        add     = {1'b0, r_rem} + {1'b0, r_e_prog};
        add_red = (add >= {1'b0, r_span}) ? (add - {1'b0, r_span}) : add;
        if (!r_ph) begin
            rem_step = dbl_red[TIME_W-1:0];
            q_bit    = (dbl >= {1'b0, r_span});
        end else begin
            rem_step = add_red[TIME_W-1:0];
            q_bit    = (add >= {1'b0, r_span});
        end
    end

    assign o_status.need_div = r_running && (r_span != '0) && (r_e_prog < r_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog     <= PROG_NONE;
            r_div_done <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_idx      <= '0;
                r_div_done <= 1'b0;
                r_q        <= '0;
                r_rem      <= '0;
                r_bit      <= 3'd6;
                r_ph       <= 1'b0;
                if (!r_running) begin
                    r_prog <= r_present ? PROG_FULL : PROG_NONE;
                end else if (r_span == '0) begin
                    r_prog <= PROG_NONE;
                end else begin
                    r_prog <= PROG_FULL;
                end
            end
            if (i_cmd.div_step) begin
                r_rem <= rem_step;
                if (!r_ph) begin
                    r_q <= {r_q[5:0], q_bit};
                    if (PROG_SCALE[r_bit]) begin
                        r_ph <= 1'b1;
                    end else if (r_bit == 3'd0) begin
                        r_div_done <= 1'b1;
                        r_prog     <= {r_q[5:0], q_bit};
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end else begin
                    r_q  <= r_q + {6'b0, q_bit};
                    r_ph <= 1'b0;
                    if (r_bit == 3'd0) begin
                        r_div_done <= 1'b1;
                        r_prog     <= r_q + {6'b0, q_bit};
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
            end
            if (i_cmd.out_next) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_status.div_done  = r_div_done;
    assign o_status.last_beat = (r_nfr == 3'd0) || ({1'b0, r_idx} == (r_nfr - 3'd1));

    assign o_frame_valid     = (r_nfr != 3'd0);
    assign o_right_byte      = o_frame_valid ? r_fr_r[r_idx] : 8'h00;
    assign o_left_byte       = o_frame_valid ? r_fr_l[r_idx] : 8'h00;
    assign o_last            = o_status.last_beat;
    assign o_update_accepted = r_accepted;
    assign o_running_now     = r_running;
    assign o_completed       = r_present && !r_running;
    assign o_progress_pct    = r_prog;

    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= PROG_FULL)
        else $error("progress above full scale");

    a_frame_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfr != 3'd1) && (r_nfr != 3'd3))
        else $error("speed frame not paired with a direction frame");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && stop_send) |=> (r_lspd == SPD_STOP && r_rdir == DIR_NONE))
        else $error("wheel stop did not clear the stored drive bytes");

endmodule

>>> design/timed_wheel_drive_sequencer.sv
// Top level of the timed wheel drive sequencer: stream ports, controller and
// datapath. Depends on twds_pkg, twds_ctrl and twds_dp.
//
// One event is taken at a time. After an input beat the block passes through
// a calculate state and an apply state to update the task and build the
// frame list, then a prepare state to set up progress, and, while a task runs
// with time left, the progress divider (a doubling step per bit of the scale
// factor 100, an add step per set bit, and a step to hand the quotient to the
// output). Results then go out one beat per cycle while the sink is ready: up
// to four frame beats, or one status beat when no frame is sent. Sink stalls
// hold the output; the next input beat is taken in the cycle after the last
// result beat. Configuration writes are taken in any cycle and should be made
// while no event is in progress.
module timed_wheel_drive_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [twds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [twds_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // left_pct [7:0], right_pct [15:8], duration_ms [47:16], now_ms [79:48]
    input  logic [79:0]                     i_s_tdata,
    // mode [2:0]
    input  logic [2:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // right_byte [7:0], left_byte [15:8], update_accepted [16], running_now [17],
    // completed [18], progress_pct [25:19], zero [31:26]
    output logic [31:0]                     o_m_tdata,
    // frame_valid [0]
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);
    import twds_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [7:0] right_byte;
    logic [7:0] left_byte;
    logic       update_accepted;
    logic       running_now;
    logic       completed;
    logic [6:0] progress_pct;

    twds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    twds_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (i_s_tuser),
        .i_left_pct        (i_s_tdata[7:0]),
        .i_right_pct       (i_s_tdata[15:8]),
        .i_duration_ms     (i_s_tdata[47:16]),
        .i_now_ms          (i_s_tdata[79:48]),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_frame_valid     (o_m_tuser),
        .o_right_byte      (right_byte),
        .o_left_byte       (left_byte),
        .o_last            (o_m_tlast),
        .o_update_accepted (update_accepted),
        .o_running_now     (running_now),
        .o_completed       (completed),
        .o_progress_pct    (progress_pct)
    );

    assign o_m_tdata = {6'b000000, progress_pct, completed, running_now,
                        update_accepted, left_byte, right_byte};

endmodule
